// ----- rtl/core/qapm_pkg.sv -----
// Shared types, constants and arithmetic helpers for the quadcopter attitude PI
// controller and X-mode motor mixer. Used by every module in rtl/core.
package qapm_pkg;

  localparam int DUTY_MAX         = 255;
  localparam int INTEG_WINDOW_DEG = 20;
  localparam int ANG_ONE          = 64;
  localparam int TRIP_DEG         = 55;
  localparam int LEVEL_DEG        = 3;
  localparam int GAIN_FRAC_BITS   = 14;

  localparam int ANG_W      = 16;
  localparam int ERR_W      = ANG_W + 1;
  localparam int INTEG_W    = 18;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 16;
  localparam int BASE_W     = 8;
  localparam int DUTY_W     = 8;
  localparam int PROD_W     = GAIN_W + 1 + INTEG_W;
  localparam int QUOT_W     = PROD_W - GAIN_FRAC_BITS;
  localparam int TSUM_W     = QUOT_W + 2;
  localparam int TERM_W     = 16;
  localparam int MIX_W      = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ERR_W-1:0] TRIP_MAG   = ERR_W'(TRIP_DEG * ANG_ONE);
  localparam logic [ERR_W-1:0] LEVEL_MAG  = ERR_W'(LEVEL_DEG * ANG_ONE);
  localparam logic [ERR_W-1:0] WINDOW_MAG = ERR_W'(INTEG_WINDOW_DEG * ANG_ONE);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PITCH_PROP   = 3'd0,
    REG_PITCH_INTEG  = 3'd1,
    REG_PITCH_RATE   = 3'd2,
    REG_ROLL_PROP    = 3'd3,
    REG_ROLL_INTEG   = 3'd4,
    REG_ROLL_RATE    = 3'd5,
    REG_YAW_PROP     = 3'd6,
    REG_INTEG_LIMITS = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] pitch_prop;
    logic [GAIN_W-1:0] pitch_integ;
    logic [GAIN_W-1:0] pitch_rate;
    logic [GAIN_W-1:0] roll_prop;
    logic [GAIN_W-1:0] roll_integ;
    logic [GAIN_W-1:0] roll_rate;
    logic [GAIN_W-1:0] yaw_prop;
  } gains_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] roll;
    logic [LIMIT_W-1:0] pitch;
  } limits_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   pitch_err;
    logic signed [ERR_W-1:0]   roll_err;
    logic signed [ERR_W-1:0]   yaw_err;
    logic signed [ANG_W-1:0]   pitch_rate;
    logic signed [ANG_W-1:0]   roll_rate;
    logic [BASE_W-1:0]         base;
    logic signed [INTEG_W-1:0] pitch_integ;
    logic signed [INTEG_W-1:0] roll_integ;
    logic                      tripped;
    logic                      level;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_push_t;

  function automatic logic [ERR_W-1:0] err_mag(input logic signed [ERR_W-1:0] v);
    return v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
  endfunction

  function automatic logic signed [PROD_W-1:0] gain_mul(input logic [GAIN_W-1:0] gain,
                                                       input logic signed [INTEG_W-1:0] val);
    return $signed({1'b0, gain}) * val;
  endfunction

  // Scales a product down by the gain fraction, rounding toward zero.
  function automatic logic signed [QUOT_W-1:0] scale_down(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] biased;
    biased = p + (p[PROD_W-1] ? $signed(PROD_W'(2 ** GAIN_FRAC_BITS - 1))
                              : $signed(PROD_W'(0)));
    return QUOT_W'(biased >>> GAIN_FRAC_BITS);
  endfunction

  function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [TSUM_W-1:0] v);
    if (v > $signed(TSUM_W'(32767))) begin
      return TERM_W'(32767);
    end else if (v < -$signed(TSUM_W'(32768))) begin
      return TERM_W'(-32768);
    end
    return TERM_W'(v);
  endfunction

  function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [MIX_W-1:0] v);
    if (v[MIX_W-1]) begin
      return '0;
    end else if (v >= $signed(MIX_W'(DUTY_MAX))) begin
      return DUTY_W'(DUTY_MAX);
    end
    return DUTY_W'(v);
  endfunction

endpackage

// ----- rtl/core/quad_attitude_pid_mixer.sv -----
// Top level of the quadcopter attitude PI controller with X-mode motor mixer.
// Holds the configuration registers and joins qapm_front, qapm_queue, qapm_back.
// Depends on qapm_pkg.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i/in_ready_o    target, measured, rates, base
//   out      output     out_valid_o/out_ready_i  four duties, tripped, level
//   cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One transaction per cycle while the queue is not full; the front-end integral
// loop closes through a single register. An accepted transaction passes through
// the queue, the multiply register, the term register and the output register.
// Reset clears the gains, limits, integrals and all valid state.
// in_ready_o depends only on queue fullness; an output stall fills the back end
// and then the queue before input is held off. Configuration is always ready.
module quad_attitude_pid_mixer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [qapm_pkg::ANG_W-1:0]     target_pitch_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]     target_roll_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]     target_yaw_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]     measured_pitch_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]     measured_roll_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]     measured_yaw_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]     pitch_rate_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]     roll_rate_i,
  input  logic [qapm_pkg::BASE_W-1:0]           base_throttle_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [qapm_pkg::DUTY_W-1:0]           motor1_duty_o,
  output logic [qapm_pkg::DUTY_W-1:0]           motor2_duty_o,
  output logic [qapm_pkg::DUTY_W-1:0]           motor3_duty_o,
  output logic [qapm_pkg::DUTY_W-1:0]           motor4_duty_o,
  output logic                                  tripped_o,
  output logic                                  level_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [qapm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [qapm_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  qapm_pkg::gains_t  gains_q, gains_d;
  qapm_pkg::limits_t limits_q, limits_d;
  qapm_pkg::q_push_t push;
  qapm_pkg::entry_t  q_entry;
  logic              q_full, q_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    gains_d  = gains_q;
    limits_d = limits_q;
    if (cfg_valid_i) begin
      case (qapm_pkg::cfg_reg_e'(cfg_index_i))
        qapm_pkg::REG_PITCH_PROP:   gains_d.pitch_prop  = cfg_data_i[qapm_pkg::GAIN_W-1:0];
        qapm_pkg::REG_PITCH_INTEG:  gains_d.pitch_integ = cfg_data_i[qapm_pkg::GAIN_W-1:0];
        qapm_pkg::REG_PITCH_RATE:   gains_d.pitch_rate  = cfg_data_i[qapm_pkg::GAIN_W-1:0];
        qapm_pkg::REG_ROLL_PROP:    gains_d.roll_prop   = cfg_data_i[qapm_pkg::GAIN_W-1:0];
        qapm_pkg::REG_ROLL_INTEG:   gains_d.roll_integ  = cfg_data_i[qapm_pkg::GAIN_W-1:0];
        qapm_pkg::REG_ROLL_RATE:    gains_d.roll_rate   = cfg_data_i[qapm_pkg::GAIN_W-1:0];
        qapm_pkg::REG_YAW_PROP:     gains_d.yaw_prop    = cfg_data_i[qapm_pkg::GAIN_W-1:0];
        qapm_pkg::REG_INTEG_LIMITS: limits_d            = cfg_data_i;
        default: begin
          gains_d = gains_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q  <= '0;
      limits_q <= '0;
    end else begin
      gains_q  <= gains_d;
      limits_q <= limits_d;
    end
  end

  assign in_ready_o = !q_full;

  qapm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .q_full_i         (q_full),
    .target_pitch_i   (target_pitch_i),
    .target_roll_i    (target_roll_i),
    .target_yaw_i     (target_yaw_i),
    .measured_pitch_i (measured_pitch_i),
    .measured_roll_i  (measured_roll_i),
    .measured_yaw_i   (measured_yaw_i),
    .pitch_rate_i     (pitch_rate_i),
    .roll_rate_i      (roll_rate_i),
    .base_throttle_i  (base_throttle_i),
    .limits_i         (limits_q),
    .push_o           (push)
  );

  qapm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  qapm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .gains_i       (gains_q),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .motor1_duty_o (motor1_duty_o),
    .motor2_duty_o (motor2_duty_o),
    .motor3_duty_o (motor3_duty_o),
    .motor4_duty_o (motor4_duty_o),
    .tripped_o     (tripped_o),
    .level_o       (level_o)
  );

endmodule

// ----- rtl/core/qapm_front.sv -----
// Front end: accepts input transactions, forms the angle errors, classifies trip
// and level, and updates the windowed, clamped integrals. Depends on qapm_pkg.
module qapm_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 q_full_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]    target_pitch_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]    target_roll_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]    target_yaw_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]    measured_pitch_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]    measured_roll_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]    measured_yaw_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]    pitch_rate_i,
  input  logic signed [qapm_pkg::ANG_W-1:0]    roll_rate_i,
  input  logic [qapm_pkg::BASE_W-1:0]          base_throttle_i,
  input  qapm_pkg::limits_t                    limits_i,
  output qapm_pkg::q_push_t                    push_o
);

  logic signed [qapm_pkg::ERR_W-1:0]   ep, er, ey;
  logic [qapm_pkg::ERR_W-1:0]          ep_mag, er_mag;
  logic                                trip, accept;
  logic                                p_win, r_win;
  logic signed [qapm_pkg::INTEG_W-1:0] p_int_q, p_int_d, r_int_q, r_int_d;
  logic signed [qapm_pkg::INTEG_W-1:0] p_sum, r_sum, p_lim, r_lim;
  logic signed [qapm_pkg::INTEG_W-1:0] p_clamped, r_clamped;

  assign ep = qapm_pkg::ERR_W'(target_pitch_i) - qapm_pkg::ERR_W'(measured_pitch_i);
  assign er = qapm_pkg::ERR_W'(target_roll_i) - qapm_pkg::ERR_W'(measured_roll_i);
  assign ey = qapm_pkg::ERR_W'(target_yaw_i) - qapm_pkg::ERR_W'(measured_yaw_i);

  assign ep_mag = qapm_pkg::err_mag(ep);
  assign er_mag = qapm_pkg::err_mag(er);
  assign trip   = (ep_mag >= qapm_pkg::TRIP_MAG) || (er_mag >= qapm_pkg::TRIP_MAG);
  assign p_win  = ep_mag <= qapm_pkg::WINDOW_MAG;
  assign r_win  = er_mag <= qapm_pkg::WINDOW_MAG;
  assign accept = in_valid_i && !q_full_i;

  assign p_lim = $signed(qapm_pkg::INTEG_W'(limits_i.pitch));
  assign r_lim = $signed(qapm_pkg::INTEG_W'(limits_i.roll));
  assign p_sum = p_int_q + qapm_pkg::INTEG_W'(ep);
  assign r_sum = r_int_q + qapm_pkg::INTEG_W'(er);

  always_comb begin
    if (p_sum >= p_lim) begin
      p_clamped = p_lim;
    end else if (p_sum <= -p_lim) begin
      p_clamped = -p_lim;
    end else begin
      p_clamped = p_sum;
    end
    if (r_sum >= r_lim) begin
      r_clamped = r_lim;
    end else if (r_sum <= -r_lim) begin
      r_clamped = -r_lim;
    end else begin
      r_clamped = r_sum;
    end
  end

  assign p_int_d = (accept && !trip && p_win) ? p_clamped : p_int_q;
  assign r_int_d = (accept && !trip && r_win) ? r_clamped : r_int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_int_q <= '0;
      r_int_q <= '0;
    end else begin
      p_int_q <= p_int_d;
      r_int_q <= r_int_d;
    end
  end

  always_comb begin
    push_o.valid             = accept;
    push_o.entry.pitch_err   = ep;
    push_o.entry.roll_err    = er;
    push_o.entry.yaw_err     = ey;
    push_o.entry.pitch_rate  = pitch_rate_i;
    push_o.entry.roll_rate   = roll_rate_i;
    push_o.entry.base        = base_throttle_i;
    push_o.entry.pitch_integ = p_win ? p_clamped : p_int_q;
    push_o.entry.roll_integ  = r_win ? r_clamped : r_int_q;
    push_o.entry.tripped     = trip;
    push_o.entry.level       = !trip && (ep_mag <= qapm_pkg::LEVEL_MAG)
                               && (er_mag <= qapm_pkg::LEVEL_MAG);
  end

endmodule

// ----- rtl/core/qapm_queue.sv -----
// Short queue of classified transactions between the front and back ends.
// Depends on qapm_pkg for the entry type and depth.
module qapm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qapm_pkg::q_push_t push_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output qapm_pkg::entry_t  entry_o
);

  qapm_pkg::entry_t             mem_q [qapm_pkg::QUEUE_DEPTH];
  logic [qapm_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [qapm_pkg::QCNT_W-1:0]  count_q, count_d;

  assign full_o  = count_q == qapm_pkg::QCNT_W'(qapm_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == qapm_pkg::QPTR_W'(qapm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == qapm_pkg::QPTR_W'(qapm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_q + 1'b1;
    end
    if (push_i.valid && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i.valid && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= qapm_pkg::QCNT_W'(qapm_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid && !pop_i |-> !full_o)
    else $error("push into full queue");

endmodule

// ----- rtl/core/qapm_back.sv -----
// Back end: multiplies by the gains, scales and saturates the three terms, mixes
// them in X mode and holds the result in the output register. Depends on qapm_pkg.
module qapm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  qapm_pkg::entry_t              q_entry_i,
  input  qapm_pkg::gains_t              gains_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [qapm_pkg::DUTY_W-1:0]   motor1_duty_o,
  output logic [qapm_pkg::DUTY_W-1:0]   motor2_duty_o,
  output logic [qapm_pkg::DUTY_W-1:0]   motor3_duty_o,
  output logic [qapm_pkg::DUTY_W-1:0]   motor4_duty_o,
  output logic                          tripped_o,
  output logic                          level_o
);

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  logic signed [qapm_pkg::PROD_W-1:0] pp_q, pi_q, pr_q, rp_q, ri_q, rr_q, yp_q;
  logic [qapm_pkg::BASE_W-1:0]        base1_q, base2_q;
  logic                               trip1_q, trip2_q, lvl1_q, lvl2_q;

  logic signed [qapm_pkg::TERM_W-1:0] tp_q, tr_q, ty_q, tp_d, tr_d, ty_d;
  logic signed [qapm_pkg::TSUM_W-1:0] tp_sum, tr_sum, ty_sum;
  logic signed [qapm_pkg::MIX_W-1:0]  b, tp, tr, ty, m1, m2, m3, m4;

  logic [qapm_pkg::DUTY_W-1:0] d1_q, d2_q, d3_q, d4_q;
  logic                        trip3_q, lvl3_q;

  assign adv3  = !v3_q || out_ready_i;
  assign adv2  = !v2_q || adv3;
  assign adv1  = !v1_q || adv2;
  assign pop_o = q_valid_i && adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= q_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      pp_q    <= qapm_pkg::gain_mul(gains_i.pitch_prop, qapm_pkg::INTEG_W'(q_entry_i.pitch_err));
      pi_q    <= qapm_pkg::gain_mul(gains_i.pitch_integ, q_entry_i.pitch_integ);
      pr_q    <= qapm_pkg::gain_mul(gains_i.pitch_rate, qapm_pkg::INTEG_W'(q_entry_i.pitch_rate));
      rp_q    <= qapm_pkg::gain_mul(gains_i.roll_prop, qapm_pkg::INTEG_W'(q_entry_i.roll_err));
      ri_q    <= qapm_pkg::gain_mul(gains_i.roll_integ, q_entry_i.roll_integ);
      rr_q    <= qapm_pkg::gain_mul(gains_i.roll_rate, qapm_pkg::INTEG_W'(q_entry_i.roll_rate));
      yp_q    <= qapm_pkg::gain_mul(gains_i.yaw_prop, qapm_pkg::INTEG_W'(q_entry_i.yaw_err));
      base1_q <= q_entry_i.base;
      trip1_q <= q_entry_i.tripped;
      lvl1_q  <= q_entry_i.level;
    end
  end

  always_comb begin
    tp_sum = qapm_pkg::TSUM_W'(qapm_pkg::scale_down(pp_q))
           + qapm_pkg::TSUM_W'(qapm_pkg::scale_down(pi_q))
           - qapm_pkg::TSUM_W'(qapm_pkg::scale_down(pr_q));
    tr_sum = qapm_pkg::TSUM_W'(qapm_pkg::scale_down(rp_q))
           + qapm_pkg::TSUM_W'(qapm_pkg::scale_down(ri_q))
           - qapm_pkg::TSUM_W'(qapm_pkg::scale_down(rr_q));
    ty_sum = qapm_pkg::TSUM_W'(qapm_pkg::scale_down(yp_q));
    tp_d   = qapm_pkg::sat_term(tp_sum);
    tr_d   = qapm_pkg::sat_term(tr_sum);
    ty_d   = qapm_pkg::sat_term(ty_sum);
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      tp_q    <= tp_d;
      tr_q    <= tr_d;
      ty_q    <= ty_d;
      base2_q <= base1_q;
      trip2_q <= trip1_q;
      lvl2_q  <= lvl1_q;
    end
  end

  always_comb begin
    b  = $signed(qapm_pkg::MIX_W'(base2_q));
    tp = qapm_pkg::MIX_W'(tp_q);
    tr = qapm_pkg::MIX_W'(tr_q);
    ty = qapm_pkg::MIX_W'(ty_q);
    m1 = b + tp + tr + ty;
    m2 = b - tp + tr - ty;
    m3 = b - tp - tr + ty;
    m4 = b + tp - tr - ty;
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      d1_q    <= trip2_q ? '0 : qapm_pkg::clamp_duty(m1);
      d2_q    <= trip2_q ? '0 : qapm_pkg::clamp_duty(m2);
      d3_q    <= trip2_q ? '0 : qapm_pkg::clamp_duty(m3);
      d4_q    <= trip2_q ? '0 : qapm_pkg::clamp_duty(m4);
      trip3_q <= trip2_q;
      lvl3_q  <= lvl2_q;
    end
  end

  assign out_valid_o   = v3_q;
  assign motor1_duty_o = d1_q;
  assign motor2_duty_o = d2_q;
  assign motor3_duty_o = d3_q;
  assign motor4_duty_o = d4_q;
  assign tripped_o     = trip3_q;
  assign level_o       = lvl3_q;

  a_trip_motors_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && trip3_q |-> d1_q == '0 && d2_q == '0 && d3_q == '0 && d4_q == '0 && !lvl3_q)
    else $error("tripped result with motors running or level set");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && v3_q && !out_ready_i |=> v2_q && $stable(tp_q) && $stable(tr_q))
    else $error("term stage lost or changed while stalled");

endmodule

// ----- tb/sv/tb_quad_attitude_pid_mixer.sv -----
// Self-checking testbench for quad_attitude_pid_mixer: directed tilt, window and trip cases,
// then randomized control updates under several gain settings and handshake pacing modes.
// Depends on qapm_pkg and the RTL of quad_attitude_pid_mixer.
module tb_quad_attitude_pid_mixer;
  import qapm_pkg::*;

  localparam int N_DIRECTED = 25;
  localparam int ITEMS_PER_PHASE = 54;
  localparam int RANDOM_PHASES = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [ANG_W-1:0] tgt_pitch;
    logic signed [ANG_W-1:0] tgt_roll;
    logic signed [ANG_W-1:0] tgt_yaw;
    logic signed [ANG_W-1:0] meas_pitch;
    logic signed [ANG_W-1:0] meas_roll;
    logic signed [ANG_W-1:0] meas_yaw;
    logic signed [ANG_W-1:0] pitch_rate;
    logic signed [ANG_W-1:0] roll_rate;
    logic [BASE_W-1:0]       base;
  } attitude_t;

  typedef struct {
    logic [3:0][DUTY_W-1:0] duty;
    logic                   tripped;
    logic                   level;
  } duty_set_t;

  class motor_duty_tracker;
    gains_t                    gains;
    limits_t                   limits;
    logic signed [INTEG_W-1:0] pitch_acc;
    logic signed [INTEG_W-1:0] roll_acc;
    duty_set_t                 pending_duties[$];
    int                        mismatches;
    int                        results_seen;
    int                        trips_seen;
    int                        levels_seen;

    function new();
      gains = '0;
      limits = '0;
      pitch_acc = '0;
      roll_acc = '0;
      mismatches = 0;
      results_seen = 0;
      trips_seen = 0;
      levels_seen = 0;
    endfunction

    function void note_config(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_PITCH_PROP:   gains.pitch_prop = d[GAIN_W-1:0];
        REG_PITCH_INTEG:  gains.pitch_integ = d[GAIN_W-1:0];
        REG_PITCH_RATE:   gains.pitch_rate = d[GAIN_W-1:0];
        REG_ROLL_PROP:    gains.roll_prop = d[GAIN_W-1:0];
        REG_ROLL_INTEG:   gains.roll_integ = d[GAIN_W-1:0];
        REG_ROLL_RATE:    gains.roll_rate = d[GAIN_W-1:0];
        REG_YAW_PROP:     gains.yaw_prop = d[GAIN_W-1:0];
        REG_INTEG_LIMITS: limits = d;
        default: ;
      endcase
    endfunction

    function int abs_err(int v);
      return (v < 0) ? -v : v;
    endfunction

    function longint gain_product(logic [GAIN_W-1:0] g, int v);
      return (longint'(g) * longint'(v)) / (longint'(1) << GAIN_FRAC_BITS);
    endfunction

    function int clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
    endfunction

    function int windowed_sum(int acc, int err, int lim);
      if (abs_err(err) <= INTEG_WINDOW_DEG * ANG_ONE) begin
        acc += err;
        if (acc >= lim) acc = lim;
        else if (acc <= -lim) acc = -lim;
      end
      return acc;
    endfunction

    function logic [DUTY_W-1:0] duty_limit(int v);
      if (v < 0) return '0;
      if (v >= DUTY_MAX) return DUTY_W'(DUTY_MAX);
      return DUTY_W'(v);
    endfunction

    function void note_attitude(attitude_t a);
      int ep, er, ey, tp, tr, ty, base;
      duty_set_t d;
      ep = int'(a.tgt_pitch) - int'(a.meas_pitch);
      er = int'(a.tgt_roll) - int'(a.meas_roll);
      ey = int'(a.tgt_yaw) - int'(a.meas_yaw);
      base = int'(a.base);
      d.duty = '0;
      d.tripped = 1'b0;
      d.level = 1'b0;
      if (abs_err(ep) >= TRIP_DEG * ANG_ONE || abs_err(er) >= TRIP_DEG * ANG_ONE) begin
        d.tripped = 1'b1;
      end else begin
        d.level = abs_err(ep) <= LEVEL_DEG * ANG_ONE && abs_err(er) <= LEVEL_DEG * ANG_ONE;
        pitch_acc = INTEG_W'(windowed_sum(int'(pitch_acc), ep, int'(limits.pitch)));
        roll_acc = INTEG_W'(windowed_sum(int'(roll_acc), er, int'(limits.roll)));
        tp = clip16(gain_product(gains.pitch_prop, ep) + gain_product(gains.pitch_integ, pitch_acc)
                    - gain_product(gains.pitch_rate, a.pitch_rate));
        tr = clip16(gain_product(gains.roll_prop, er) + gain_product(gains.roll_integ, roll_acc)
                    - gain_product(gains.roll_rate, a.roll_rate));
        ty = clip16(gain_product(gains.yaw_prop, ey));
        d.duty[0] = duty_limit(base + tp + tr + ty);
        d.duty[1] = duty_limit(base - tp + tr - ty);
        d.duty[2] = duty_limit(base - tp - tr + ty);
        d.duty[3] = duty_limit(base + tp - tr - ty);
      end
      pending_duties.push_back(d);
    endfunction

    function void compare_field(string name, logic [DUTY_W-1:0] want, logic [DUTY_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_duties(duty_set_t got);
      duty_set_t want;
      if (pending_duties.size() == 0) begin
        $display("%0t: unexpected result, actual duties %0d %0d %0d %0d tripped %0d level %0d",
                 $time, got.duty[0], got.duty[1], got.duty[2], got.duty[3], got.tripped,
                 got.level);
        mismatches++;
        return;
      end
      want = pending_duties.pop_front();
      results_seen++;
      if (want.tripped) trips_seen++;
      if (want.level) levels_seen++;
      for (int m = 0; m < 4; m++) begin
        compare_field($sformatf("motor%0d_duty", m + 1), want.duty[m], got.duty[m]);
      end
      compare_field("tripped", DUTY_W'(want.tripped), DUTY_W'(got.tripped));
      compare_field("level", DUTY_W'(want.level), DUTY_W'(got.level));
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [ANG_W-1:0]  target_pitch_i;
  logic signed [ANG_W-1:0]  target_roll_i;
  logic signed [ANG_W-1:0]  target_yaw_i;
  logic signed [ANG_W-1:0]  measured_pitch_i;
  logic signed [ANG_W-1:0]  measured_roll_i;
  logic signed [ANG_W-1:0]  measured_yaw_i;
  logic signed [ANG_W-1:0]  pitch_rate_i;
  logic signed [ANG_W-1:0]  roll_rate_i;
  logic [BASE_W-1:0]        base_throttle_i;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [DUTY_W-1:0]        motor1_duty_o;
  logic [DUTY_W-1:0]        motor2_duty_o;
  logic [DUTY_W-1:0]        motor3_duty_o;
  logic [DUTY_W-1:0]        motor4_duty_o;
  logic                     tripped_o;
  logic                     level_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;

  motor_duty_tracker tracker;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int directed_rows [N_DIRECTED][9] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 255},
    '{192, -192, 0, 0, 0, 0, 0, 0, 128},
    '{193, 0, 0, 0, 0, 0, 0, 0, 128},
    '{0, -193, 0, 0, 0, 0, 0, 0, 128},
    '{1280, -1280, 0, 0, 0, 0, 0, 0, 128},
    '{1281, -1281, 0, 0, 0, 0, 0, 0, 128},
    '{3519, -3519, 0, 0, 0, 0, 0, 0, 128},
    '{3520, 0, 0, 0, 0, 0, 0, 0, 128},
    '{0, -3520, 0, 0, 0, 0, 0, 0, 128},
    '{-32768, 0, 0, 32767, 0, 0, 0, 0, 200},
    '{0, 32767, 0, 0, -32768, 0, 0, 0, 200},
    '{0, 0, 32767, 0, 0, -32768, 0, 0, 100},
    '{0, 0, -32768, 0, 0, 32767, 0, 0, 100},
    '{0, 0, 0, 0, 0, 0, 32767, -32768, 128},
    '{0, 0, 0, 0, 0, 0, -32768, 32767, 128},
    '{32767, -32768, 0, 32767, -32768, 0, 0, 0, 60},
    '{-32768, 32767, 5, -32768, 32767, -5, 0, 0, 60},
    '{1280, 1280, 0, 0, 0, 0, 0, 0, 128},
    '{1280, 1280, 0, 0, 0, 0, 0, 0, 128},
    '{1280, 1280, 0, 0, 0, 0, 0, 0, 255},
    '{-1280, -1280, 0, 0, 0, 0, 0, 0, 0},
    '{-1280, -1280, 0, 0, 0, 0, 0, 0, 128},
    '{-1280, -1280, 0, 0, 0, 0, 0, 0, 128},
    '{-1280, -1280, 0, 0, 0, 0, 0, 0, 128}
  };

  quad_attitude_pid_mixer uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    duty_set_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.duty = {motor4_duty_o, motor3_duty_o, motor2_duty_o, motor1_duty_o};
      got.tripped = tripped_o;
      got.level = level_o;
      tracker.check_duties(got);
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic int spread(input int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic int tilt_error();
    case ($urandom_range(0, 4))
      0: return spread(LEVEL_DEG * ANG_ONE);
      1: return spread(TRIP_DEG * ANG_ONE);
      default: return spread(INTEG_WINDOW_DEG * ANG_ONE);
    endcase
  endfunction

  // Picks a measured angle so that measured plus err still fits the angle width.
  function automatic logic [2*ANG_W-1:0] angle_pair(input int err);
    int lo, hi, m;
    lo = (err < 0) ? -32768 - err : -32768;
    hi = (err > 0) ? 32767 - err : 32767;
    m = lo + int'($urandom_range(0, hi - lo));
    return {ANG_W'(m + err), ANG_W'(m)};
  endfunction

  function automatic attitude_t random_attitude();
    attitude_t a;
    if ($urandom_range(0, 99) < 15) begin
      {a.tgt_pitch, a.tgt_roll, a.tgt_yaw, a.meas_pitch} = {$urandom, $urandom};
      {a.meas_roll, a.meas_yaw, a.pitch_rate, a.roll_rate} = {$urandom, $urandom};
    end else begin
      {a.tgt_pitch, a.meas_pitch} = angle_pair(tilt_error());
      {a.tgt_roll, a.meas_roll} = angle_pair(tilt_error());
      {a.tgt_yaw, a.meas_yaw} = angle_pair(spread(($urandom_range(0, 3) == 0) ? 65535 : 2000));
      a.pitch_rate = ($urandom_range(0, 3) == 0) ? ANG_W'($urandom) : ANG_W'(spread(512));
      a.roll_rate = ($urandom_range(0, 3) == 0) ? ANG_W'($urandom) : ANG_W'(spread(512));
    end
    a.base = BASE_W'($urandom);
    return a;
  endfunction

  function automatic logic [LIMIT_W-1:0] random_limit();
    return ($urandom_range(0, 3) == 0) ? LIMIT_W'($urandom_range(0, 300)) : LIMIT_W'($urandom);
  endfunction

  task automatic send_item(input attitude_t a);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_pitch_i <= a.tgt_pitch;
    target_roll_i <= a.tgt_roll;
    target_yaw_i <= a.tgt_yaw;
    measured_pitch_i <= a.meas_pitch;
    measured_roll_i <= a.meas_roll;
    measured_yaw_i <= a.meas_yaw;
    pitch_rate_i <= a.pitch_rate;
    roll_rate_i <= a.roll_rate;
    base_throttle_i <= a.base;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_attitude(a);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending_duties.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_gains(input int phase);
    cfg_reg_e r;
    logic [CFG_DATA_W-1:0] d;
    r = r.first();
    do begin
      if (phase == 1) begin
        d = '1;
      end else if (phase == 2) begin
        d = '0;
      end else if (phase == 0) begin
        case (r)
          REG_PITCH_PROP, REG_ROLL_PROP:   d = 512;
          REG_PITCH_INTEG, REG_ROLL_INTEG: d = 64;
          REG_PITCH_RATE, REG_ROLL_RATE:   d = 256;
          REG_YAW_PROP:                    d = 384;
          default:                         d = {16'd3000, 16'd2000};
        endcase
      end else if (r == REG_INTEG_LIMITS) begin
        d = {random_limit(), random_limit()};
      end else begin
        d = {16'($urandom),
             ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047))};
      end
      cfg_valid_i <= 1'b1;
      cfg_index_i <= r;
      cfg_data_i <= d;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      tracker.note_config(r, d);
      r = r.next();
    end while (r != r.first());
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("quad_attitude_pid_mixer: mismatch");
    $finish;
  end

  initial begin : stimulus
    attitude_t a;
    int mode;
    tracker = new();
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    target_pitch_i <= '0;
    target_roll_i <= '0;
    target_yaw_i <= '0;
    measured_pitch_i <= '0;
    measured_roll_i <= '0;
    measured_yaw_i <= '0;
    pitch_rate_i <= '0;
    roll_rate_i <= '0;
    base_throttle_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_PITCH_PROP;
    cfg_data_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_gains(0);
    for (int i = 0; i < N_DIRECTED; i++) begin
      a.tgt_pitch = ANG_W'(directed_rows[i][0]);
      a.tgt_roll = ANG_W'(directed_rows[i][1]);
      a.tgt_yaw = ANG_W'(directed_rows[i][2]);
      a.meas_pitch = ANG_W'(directed_rows[i][3]);
      a.meas_roll = ANG_W'(directed_rows[i][4]);
      a.meas_yaw = ANG_W'(directed_rows[i][5]);
      a.pitch_rate = ANG_W'(directed_rows[i][6]);
      a.roll_rate = ANG_W'(directed_rows[i][7]);
      a.base = BASE_W'(directed_rows[i][8]);
      send_item(a);
    end

    for (int p = 1; p <= RANDOM_PHASES; p++) begin
      settle();
      load_gains(p);
      mode = p % 4;
      send_idle_pct = (mode == 1) ? 86 : (mode == 3) ? 9 : 0;
      recv_stall_pct = (mode == 2) ? 86 : (mode == 3) ? 9 : 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 4 && i == ITEMS_PER_PHASE / 2) settle();
        send_item(random_attitude());
      end
    end
    settle();

    $display("Checked %0d control updates over %0d gain settings and four pacing modes.",
             tracker.results_seen, RANDOM_PHASES + 1);
    $display("Expected %0d tilt trips and %0d level flags among them.",
             tracker.trips_seen, tracker.levels_seen);
    if (tracker.mismatches == 0) begin
      $display("quad_attitude_pid_mixer: match");
    end else begin
      $display("quad_attitude_pid_mixer: mismatch");
    end
    $finish;
  end

endmodule
